@@ rtl/sw_med_pkg.sv @@
`timescale 1ns / 1ps

package sw_med_pkg;

  localparam int WIN_MAX     = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_W       = 5;
  localparam int FILL_W      = $clog2(WIN_MAX + 1);
  localparam int AGE_W       = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int MED_W       = SAMPLE_BITS + 1;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(3);

  // Register indexes (word index taken from paddr[ADDR_W-1:2])
  typedef enum logic [ADDR_W-3:0] {
    REG_WINDOW_SIZE = 1'b0
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MED_W-1:0]       median_t;

  // Stored state of a cell as seen by its left neighbour
  typedef struct packed {
    sample_t          val;
    logic [AGE_W-1:0] age;
    logic             occ;
    logic             gt;
  } sw_raw_t;

  // Post-removal view of a cell as seen by its right neighbour
  typedef struct packed {
    sample_t          val;
    logic [AGE_W-1:0] age;
    logic             occ;
    logic             ge;
  } sw_view_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic             step;
    logic             flush;
    logic             clear;
    logic             full;
    logic [AGE_W-1:0] last_age;
    sample_t          sample;
  } sw_ctrl_t;

endpackage

@@ rtl/sw_med_cell.sv @@
`timescale 1ns / 1ps

module sw_med_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sw_med_pkg::sw_ctrl_t  ctrl,
  input  sw_med_pkg::sw_raw_t   right_raw,
  input  sw_med_pkg::sw_view_t  left_view,
  input  logic                  del_in,
  output sw_med_pkg::sw_raw_t   raw_out,
  output sw_med_pkg::sw_view_t  view_out,
  output logic                  del_out
);
  import sw_med_pkg::*;

  sample_t          val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             occ_r, occ_nxt;
  logic             occ_eff;
  logic             del_here;
  logic             shifted;
  sw_view_t         view;

  assign occ_eff  = occ_r & ~ctrl.clear;
  assign del_here = occ_eff & ctrl.full & (age_r == ctrl.last_age);
  assign shifted  = del_in | del_here;
  assign del_out  = shifted;

  assign raw_out.val = val_r;
  assign raw_out.age = age_r;
  assign raw_out.occ = occ_eff;
  assign raw_out.gt  = (val_r > ctrl.sample);

  // Close the gap left by the removed entry
  always_comb begin
    if (shifted) begin
      view.val = right_raw.val;
      view.age = right_raw.age;
      view.occ = right_raw.occ;
      view.ge  = ~right_raw.occ | right_raw.gt;
    end else begin
      view.val = val_r;
      view.age = age_r;
      view.occ = occ_eff;
      view.ge  = ~occ_eff | raw_out.gt;
    end
  end

  assign view_out = view;

  // Open a slot for the new sample at the first position that is empty or above it
  always_comb begin
    if (!view.ge) begin
      val_nxt = view.val;
      age_nxt = view.age + AGE_W'(1);
      occ_nxt = view.occ;
    end else if (!left_view.ge) begin
      val_nxt = ctrl.sample;
      age_nxt = '0;
      occ_nxt = 1'b1;
    end else begin
      val_nxt = left_view.val;
      age_nxt = left_view.age + AGE_W'(1);
      occ_nxt = left_view.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctrl.flush) begin
      occ_r <= 1'b0;
    end else if (ctrl.step) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

@@ rtl/sliding_window_median.sv @@
`timescale 1ns / 1ps
// Running median over the last window_size signed samples.
// Input channel: in_valid / in_stall carry one sample per transaction, with
//   in_starts_sequence emptying the window before that sample enters.
// Output channel: out_valid / out_stall carry the median times two (one
//   fractional bit). A transaction yields a result only once the window holds
//   window_size samples; before that no result appears.
// Throughput: one sample per cycle while in_stall is low. The sorted window
//   lives in a row of WIN_MAX compare-and-shift cells that remove the oldest
//   entry and insert the new one in the same cycle.
// Result path: an accepted transaction first updates the cells, then the median
//   is selected and added into the output register, and out_valid rises.
// Backpressure: while out_stall holds a result in the output register, one
//   further median can wait in the middle stage; in_stall rises only when both
//   are full.
// Reset empties the window, sets window_size to 3 and drops pending results.
// Writing window_size over the APB port empties the window as well; write only
//   while no transaction is in flight.
module sliding_window_median (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sw_med_pkg::sample_t               in_sample,
  input  logic                              in_starts_sequence,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output sw_med_pkg::median_t               out_median_halves,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sw_med_pkg::ADDR_W-1:0]     paddr,
  input  logic [sw_med_pkg::DATA_W-1:0]     pwdata,
  output logic [sw_med_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);
  import sw_med_pkg::*;

  logic [CFG_W-1:0]  window_size_r;
  logic              cfg_wr;
  logic              reg_hit;
  logic [FILL_W-1:0] eff_w;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_eff;
  logic              full;
  logic              accept;
  logic              out_take;
  logic              emit_r, emit_nxt;
  logic              out_valid_r;
  median_t           out_median_r;
  logic [FILL_W-1:0] mid_lo, mid_hi;
  sample_t           lo_val, hi_val;

  sw_ctrl_t          ctrl;
  sw_raw_t           raw_c  [WIN_MAX];
  sw_view_t          view_c [WIN_MAX];
  logic [WIN_MAX:0]  del_c;

  // ---------------------------------------------------------------------------
  // APB register: one word, the window size
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_wr && reg_hit) begin
      window_size_r <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? DATA_W'(window_size_r) : '0;

  // Clamp the window to 1..WIN_MAX
  always_comb begin
    if (window_size_r == '0) begin
      eff_w = FILL_W'(1);
    end else if (int'(window_size_r) > WIN_MAX) begin
      eff_w = FILL_W'(WIN_MAX);
    end else begin
      eff_w = FILL_W'(window_size_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: hold the input only when both result stages are occupied
  // ---------------------------------------------------------------------------
  assign out_take = ~out_valid_r | ~out_stall;
  assign in_stall = emit_r & ~out_take;
  assign accept   = in_valid & ~in_stall;

  // Fill count; a start-of-sequence transaction sees an empty window
  assign fill_eff = in_starts_sequence ? '0 : fill_r;
  assign full     = (fill_eff >= eff_w);
  assign fill_nxt = full ? fill_eff : fill_eff + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg_wr && reg_hit) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: cell 0 holds the smallest sample
  // ---------------------------------------------------------------------------
  assign ctrl.step     = accept;
  assign ctrl.flush    = cfg_wr & reg_hit;
  assign ctrl.clear    = in_starts_sequence;
  assign ctrl.full     = full;
  assign ctrl.last_age = AGE_W'(eff_w - FILL_W'(1));
  assign ctrl.sample   = in_sample;

  assign del_c[0] = 1'b0;

  for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
    sw_raw_t  right_raw;
    sw_view_t left_view;

    if (i == WIN_MAX - 1) begin : g_tail
      assign right_raw = '0;
    end else begin : g_mid
      assign right_raw = raw_c[i+1];
    end

    if (i == 0) begin : g_head
      assign left_view = '0;
    end else begin : g_link
      assign left_view = view_c[i-1];
    end

    sw_med_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .right_raw (right_raw),
      .left_view (left_view),
      .del_in    (del_c[i]),
      .raw_out   (raw_c[i]),
      .view_out  (view_c[i]),
      .del_out   (del_c[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Median: pick the middle cells by decoded taps, add in the output stage
  // ---------------------------------------------------------------------------
  assign mid_lo = (eff_w - FILL_W'(1)) >> 1;
  assign mid_hi = eff_w >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WIN_MAX; i++) begin
      if (mid_lo == FILL_W'(i)) begin
        lo_val = lo_val | raw_c[i].val;
      end
      if (mid_hi == FILL_W'(i)) begin
        hi_val = hi_val | raw_c[i].val;
      end
    end
  end

  // Flag a result whenever the window is full after this transaction; hold it while stalled
  assign emit_nxt = (accept & (fill_nxt == eff_w)) | (emit_r & ~out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
      if (out_take) begin
        out_valid_r <= emit_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && emit_r) begin
      out_median_r <= MED_W'(lo_val) + MED_W'(hi_val);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_median_halves = out_median_r;

endmodule

@@ rtl/sw_med_chk.sv @@
`timescale 1ns / 1ps

module sw_med_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sw_med_pkg::median_t           out_median_halves,
  input  logic                          pready
);
  import sw_med_pkg::*;

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_halves))
    else $error("result changed while stalled");

  // Input backpressure only arises from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted input transaction
  a_rose_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching input transaction");

  // Reset drops any pending result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind sliding_window_median sw_med_chk u_sw_med_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_median_halves (out_median_halves),
  .pready            (pready)
);
